FILE: design/hkt_pkg.sv
// Package: shared constants, types and key mapping functions for the typematic core.
package hkt_pkg;

  localparam int SlotCountDefault = 16;
  localparam int KeysDefault      = 6;
  localparam int MaxOut           = 15;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_ACT  = 2'd2;

  localparam logic [4:0] ACT_NONE      = 5'd0;
  localparam logic [4:0] ACT_DEL_LEFT  = 5'd16;
  localparam logic [4:0] ACT_DEL_RIGHT = 5'd17;

  localparam logic [7:0] KEY_ESC   = 8'h29;
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_DEL  = 8'h7F;

  localparam logic [1:0] REG_RAW    = 2'd0;
  localparam logic [1:0] REG_DELAY  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EMIT, ST_TICK, ST_TEMIT
  } state_t;

  // One produced result before slot tagging.
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] act;
  } emit_t;

  // What a lane reports about one key of a report.
  typedef struct packed {
    logic  is_new;
    logic  productive;
    emit_t em;
  } lane_res_t;

  function automatic logic f_ctrl(input logic [7:0] m);
    return (m & 8'h11) != 8'h00;
  endfunction
  function automatic logic f_shift(input logic [7:0] m);
    return (m & 8'h22) != 8'h00;
  endfunction
  function automatic logic f_alt(input logic [7:0] m);
    return (m & 8'h44) != 8'h00;
  endfunction

  function automatic logic [7:0] table_char(input logic [7:0] k, input logic s);
    logic [7:0] c;
    c = 8'h00;
    if (k >= 8'h04 && k <= 8'h1D) c = s ? (8'h41 + k - 8'h04) : (8'h61 + k - 8'h04);
    else begin
      case (k)
        8'h1E: c = s ? 8'h21 : 8'h31;
        8'h1F: c = s ? 8'h40 : 8'h32;
        8'h20: c = s ? 8'h23 : 8'h33;
        8'h21: c = s ? 8'h24 : 8'h34;
        8'h22: c = s ? 8'h25 : 8'h35;
        8'h23: c = s ? 8'h5E : 8'h36;
        8'h24: c = s ? 8'h26 : 8'h37;
        8'h25: c = s ? 8'h2A : 8'h38;
        8'h26: c = s ? 8'h28 : 8'h39;
        8'h27: c = s ? 8'h29 : 8'h30;
        8'h28: c = 8'h0A;
        8'h2A: c = 8'h08;
        8'h2B: c = 8'h09;
        8'h2C: c = 8'h20;
        8'h2D: c = s ? 8'h5F : 8'h2D;
        8'h2E: c = s ? 8'h2B : 8'h3D;
        8'h2F: c = s ? 8'h7B : 8'h5B;
        8'h30: c = s ? 8'h7D : 8'h5D;
        8'h31: c = s ? 8'h7C : 8'h5C;
        8'h32: c = s ? 8'h7C : 8'h5C;
        8'h33: c = s ? 8'h3A : 8'h3B;
        8'h34: c = s ? 8'h22 : 8'h27;
        8'h35: c = s ? 8'h7E : 8'h60;
        8'h36: c = s ? 8'h3C : 8'h2C;
        8'h37: c = s ? 8'h3E : 8'h2E;
        8'h38: c = s ? 8'h3F : 8'h2F;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [4:0] map_action(input logic [7:0] k, input logic [7:0] m);
    logic s, a;
    logic [4:0] r;
    s = f_shift(m);
    a = f_alt(m);
    r = ACT_NONE;
    if (!f_ctrl(m)) begin
      case (k)
        8'h50: r = s ? 5'd2 : 5'd1;
        8'h4F: r = s ? 5'd4 : 5'd3;
        8'h4A: r = s ? 5'd10 : 5'd9;
        8'h4D: r = s ? 5'd12 : 5'd11;
        8'h2A: r = a ? 5'd13 : ACT_DEL_LEFT;
        8'h4C: r = ACT_DEL_RIGHT;
        8'h52: r = 5'd14;
        8'h51: r = 5'd15;
        default: r = ACT_NONE;
      endcase
      if (a) begin
        case (k)
          8'h0B: r = s ? 5'd2 : 5'd1;
          8'h0F: r = s ? 5'd4 : 5'd3;
          8'h05: r = s ? 5'd6 : 5'd5;
          8'h1A: r = s ? 5'd8 : 5'd7;
          8'h04: r = s ? 5'd10 : 5'd9;
          8'h08: r = s ? 5'd12 : 5'd11;
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic emit_t act_emit(input logic [4:0] a);
    emit_t e;
    e = '0;
    if (a == ACT_DEL_LEFT) begin
      e.vld = 1'b1; e.kind = KIND_CHAR; e.ch = BYTE_BS;
    end else if (a == ACT_DEL_RIGHT) begin
      e.vld = 1'b1; e.kind = KIND_CHAR; e.ch = BYTE_DEL;
    end else if (a != ACT_NONE) begin
      e.vld = 1'b1; e.kind = KIND_ACT; e.act = 4'(a - 5'd1);
    end
    return e;
  endfunction

  function automatic emit_t raw_emit(input logic [7:0] k, input logic s);
    emit_t e;
    logic [7:0] c;
    e = '0;
    c = table_char(k, s);
    if (k == KEY_ESC) begin
      e.vld = 1'b1; e.kind = KIND_CHAR; e.ch = BYTE_ESC;
    end else if (c != 8'h00) begin
      e.vld = 1'b1; e.kind = KIND_CHAR; e.ch = c;
    end
    return e;
  endfunction

endpackage

FILE: design/hkt_if.sv
// Interfaces: valid/ready channels for input transactions and results.
interface hkt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  slot;
  logic [63:0] generation;
  logic [7:0]  modifiers;
  logic [7:0]  key_a;
  logic [7:0]  key_b;
  logic [7:0]  key_c;
  logic [7:0]  key_d;
  logic [7:0]  key_e;
  logic [7:0]  key_f;
  logic [7:0]  key_count;
  logic [39:0] now_ms;
  modport source (output valid, cmd, slot, generation, modifiers, key_a, key_b, key_c,
                  key_d, key_e, key_f, key_count, now_ms, input ready);
  modport sink (input valid, cmd, slot, generation, modifiers, key_a, key_b, key_c,
                key_d, key_e, key_f, key_count, now_ms, output ready);
endinterface

interface hkt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_byte;
  logic [3:0] action_code;
  logic [3:0] from_slot;
  logic       last;
  modport source (output valid, kind, char_byte, action_code, from_slot, last, input ready);
  modport sink (input valid, kind, char_byte, action_code, from_slot, last, output ready);
endinterface

FILE: design/hkt_lane.sv
// Key lane: novelty test against held keys and mapping of one report key.
module hkt_lane #(
  parameter int KEYS = hkt_pkg::KeysDefault
) (
  input  logic [7:0]            key,
  input  logic [KEYS-1:0][7:0]  prev,
  input  logic [7:0]            mods,
  input  logic                  raw_mode,
  output hkt_pkg::lane_res_t    res
);
  import hkt_pkg::*;

  logic       seen;
  logic [4:0] act;
  logic [7:0] c;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < KEYS; j++) if (prev[j] == key) seen = 1'b1;
    act = map_action(key, mods);
    c   = table_char(key, f_shift(mods));
    res = '0;
    res.is_new = !seen && !key[7];
    if (raw_mode) res.em = raw_emit(key, f_shift(mods));
    else if (act != ACT_NONE) res.em = act_emit(act);
    else if (c != 8'h00) begin
      res.em.vld = 1'b1; res.em.kind = KIND_CHAR; res.em.ch = c;
    end
    res.productive = res.is_new && res.em.vld;
    if (!res.is_new) res.em = '0;
  end
endmodule

FILE: design/hkt_merge.sv
// Merge stage: gathers lane findings into an emit list and the newest productive key.
module hkt_merge #(
  parameter int KEYS = hkt_pkg::KeysDefault
) (
  input  hkt_pkg::lane_res_t [KEYS-1:0] lres,
  input  logic [KEYS-1:0][7:0]          keys,
  input  logic [2:0]                    cnt,
  output hkt_pkg::emit_t [KEYS-1:0]     ems,
  output logic [7:0]                    fresh
);
  import hkt_pkg::*;

  always_comb begin
    fresh = 8'h00;
    for (int i = 0; i < KEYS; i++) begin
      ems[i] = '0;
      if (3'(i) < cnt) begin
        ems[i] = lres[i].em;
        if (lres[i].productive) fresh = keys[i];
      end
    end
  end
endmodule

FILE: design/hid_keyboard_report_typematic_core.sv
// Top level: slot state, lanes, result sequencer and configuration registers.
// A report is compared against the slot's held keys by one lane per key, combinationally in the
// cycle it is accepted; the EMIT state then steps through the key positions in order up to the
// last key that yields a result and loads each result into the output register. A tick walks
// slots 1..SLOT_COUNT-1 one per cycle unless a held result waits for the output register, then
// closes the walk and sends the held last result from the TEMIT state. A due slot stalls the
// walk only while the output register is still full. Results sit in an output register, so
// out_ready low stalls the sequencer. At most 15 results per transaction leave the block.
module hid_keyboard_report_typematic_core #(
  parameter int SLOT_COUNT = hkt_pkg::SlotCountDefault,
  parameter int KEYS       = hkt_pkg::KeysDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  hkt_in_if.sink      in_ch,
  hkt_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hkt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);

  logic        raw_r;
  logic [15:0] dly_r, per_r;

  logic [SLOT_COUNT-1:0]           act_r;
  logic [SLOT_COUNT-1:0][63:0]     gen_r;
  logic [SLOT_COUNT-1:0][KEYS-1:0][7:0] held_r;
  logic [SLOT_COUNT-1:0][7:0]      rcode_r, rmods_r;
  logic [SLOT_COUNT-1:0][4:0]      ract_r;
  logic [SLOT_COUNT-1:0][39:0]     rdl_r;

  state_t state_r, state_nxt;
  emit_t [KEYS-1:0] ems_r;
  logic [2:0]  ecnt_r, eidx_r;
  logic [3:0]  ocnt_r;
  logic [3:0]  oslot_r;
  logic [SW:0] tslot_r;
  logic [39:0] now_r;
  emit_t       tem_r;
  logic        tlast_r;

  logic        ovld_r, olast_r;
  logic [1:0]  okind_r;
  logic [7:0]  och_r;
  logic [3:0]  oact_r, ofrom_r;

  // configuration
  logic wr;
  logic [1:0] ridx;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  always_comb begin
    case (ridx)
      REG_RAW:    cfg_prdata = {31'd0, raw_r};
      REG_DELAY:  cfg_prdata = {16'd0, dly_r};
      REG_PERIOD: cfg_prdata = {16'd0, per_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // report decode
  logic [SW-1:0] s_idx;
  logic [KEYS-1:0][7:0] keys;
  logic [2:0] cnt;
  logic in_ok, same;
  logic [KEYS-1:0][7:0] prev;
  lane_res_t [KEYS-1:0] lres;
  emit_t [KEYS-1:0] ems;
  logic [7:0] fresh;
  logic [47:0] kall;

  assign s_idx = SW'(in_ch.slot);
  assign kall = {in_ch.key_f, in_ch.key_e, in_ch.key_d, in_ch.key_c, in_ch.key_b, in_ch.key_a};
  always_comb begin
    for (int i = 0; i < KEYS; i++) keys[i] = kall[8*i +: 8];
    cnt = (in_ch.key_count > 8'(KEYS)) ? 3'(KEYS) : in_ch.key_count[2:0];
  end
  assign in_ok = in_ch.slot != 4'd0 && 32'(in_ch.slot) < SLOT_COUNT && in_ch.generation != 0;
  assign same = act_r[s_idx] && gen_r[s_idx] == in_ch.generation;
  assign prev = same ? held_r[s_idx] : '0;

  for (genvar g = 0; g < KEYS; g++) begin : g_lane
    hkt_lane #(.KEYS(KEYS)) u_lane (
      .key(keys[g]), .prev(prev), .mods(in_ch.modifiers), .raw_mode(raw_r), .res(lres[g])
    );
  end
  hkt_merge #(.KEYS(KEYS)) u_merge (.lres(lres), .keys(keys), .cnt(cnt), .ems(ems),
                                     .fresh(fresh));

  // tick evaluation
  logic [SW-1:0] t_idx;
  logic t_due;
  emit_t t_em;
  assign t_idx = tslot_r[SW-1:0];
  always_comb begin
    t_due = act_r[t_idx] && rcode_r[t_idx] != 8'h00 && !(now_r < rdl_r[t_idx]);
    t_em = '0;
    if (ract_r[t_idx] != ACT_NONE) begin
      if (map_action(rcode_r[t_idx], rmods_r[t_idx]) == ract_r[t_idx])
        t_em = act_emit(ract_r[t_idx]);
    end else if (raw_r) t_em = raw_emit(rcode_r[t_idx], f_shift(rmods_r[t_idx]));
    else begin
      t_em.ch = table_char(rcode_r[t_idx], f_shift(rmods_r[t_idx]));
      t_em.vld = t_em.ch != 8'h00;
      t_em.kind = KIND_CHAR;
    end
  end

  logic out_free, in_fire;
  assign out_free = !ovld_r || out_ch.ready;
  assign in_ch.ready = state_r == ST_IDLE;
  assign in_fire = in_ch.valid && in_ch.ready;

  // any emitting result remaining after index eidx_r
  logic more_rep;
  always_comb begin
    more_rep = 1'b0;
    for (int i = 0; i < KEYS; i++)
      if (3'(i) > eidx_r && ems_r[i].vld) more_rep = 1'b1;
  end

  // load the output register this cycle
  logic oload;
  always_comb begin
    unique case (state_r)
      ST_EMIT:  oload = out_free && eidx_r < ecnt_r && ems_r[eidx_r].vld;
      ST_TICK:  oload = out_free && 32'(tslot_r) < SLOT_COUNT && tem_r.vld && t_due &&
                        t_em.vld && ocnt_r < 4'(MaxOut);
      ST_TEMIT: oload = out_free && tem_r.vld && ocnt_r < 4'(MaxOut);
      default:  oload = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        if (in_ch.cmd == CMD_REPORT && in_ok) state_nxt = ST_EMIT;
        else if (in_ch.cmd == CMD_TICK) state_nxt = ST_TICK;
      end
      ST_SCAN: state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && (eidx_r >= ecnt_r || !more_rep && !ems_r[eidx_r].vld))
        state_nxt = ST_IDLE;
        else if (out_free && !more_rep) state_nxt = ST_IDLE;
      ST_TICK: if (32'(tslot_r) >= SLOT_COUNT) state_nxt = ST_TEMIT;
      ST_TEMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      raw_r <= 1'b0; dly_r <= 16'd400; per_r <= 16'd40;
      act_r <= '0; gen_r <= '0; held_r <= '0; rcode_r <= '0; rmods_r <= '0;
      ract_r <= '0; rdl_r <= '0;
      ovld_r <= 1'b0; ocnt_r <= '0; tem_r <= '0; eidx_r <= '0; ecnt_r <= '0;
      tslot_r <= '0; tlast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr) begin
        case (ridx)
          REG_RAW:    raw_r <= cfg_pwdata[0];
          REG_DELAY:  dly_r <= cfg_pwdata[15:0];
          REG_PERIOD: per_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (oload) ovld_r <= 1'b1;
      else if (ovld_r && out_ch.ready) ovld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_fire) begin
          ocnt_r <= '0; eidx_r <= '0; now_r <= in_ch.now_ms; tem_r <= '0;
          oslot_r <= in_ch.slot; ecnt_r <= cnt;
          tslot_r <= (SW+1)'(1);
          if (in_ch.cmd == CMD_REMOVE && in_ok && same) begin
            act_r[s_idx] <= 1'b0; gen_r[s_idx] <= '0; held_r[s_idx] <= '0;
            rcode_r[s_idx] <= '0; rmods_r[s_idx] <= '0; ract_r[s_idx] <= ACT_NONE;
            rdl_r[s_idx] <= '0;
          end
          if (in_ch.cmd == CMD_REPORT && in_ok) begin
            ems_r <= ems;
            act_r[s_idx] <= 1'b1; gen_r[s_idx] <= in_ch.generation;
            for (int i = 0; i < KEYS; i++)
              held_r[s_idx][i] <= (3'(i) < cnt) ? keys[i] : 8'h00;
            if (fresh != 8'h00) begin
              rcode_r[s_idx] <= fresh; rmods_r[s_idx] <= in_ch.modifiers;
              ract_r[s_idx] <= map_action(fresh, in_ch.modifiers);
              rdl_r[s_idx] <= in_ch.now_ms + 40'(dly_r);
            end else if (same && rcode_r[s_idx] != 8'h00) begin
              logic hit;
              hit = 1'b0;
              for (int i = 0; i < KEYS; i++)
                if (3'(i) < cnt && keys[i] == rcode_r[s_idx]) hit = 1'b1;
              if (hit) rmods_r[s_idx] <= in_ch.modifiers;
              else if (cnt != 3'd0) begin
                rcode_r[s_idx] <= keys[cnt - 3'd1]; rmods_r[s_idx] <= in_ch.modifiers;
                ract_r[s_idx] <= map_action(keys[cnt - 3'd1], in_ch.modifiers);
                rdl_r[s_idx] <= in_ch.now_ms + 40'(dly_r);
              end else begin
                rcode_r[s_idx] <= '0; rmods_r[s_idx] <= '0; ract_r[s_idx] <= ACT_NONE;
                rdl_r[s_idx] <= '0;
              end
            end else if (!same) begin
              rcode_r[s_idx] <= '0; rmods_r[s_idx] <= '0; ract_r[s_idx] <= ACT_NONE;
              rdl_r[s_idx] <= '0;
            end
          end
        end
        ST_SCAN: ;
        ST_EMIT: if (out_free) begin
          if (eidx_r < ecnt_r && ems_r[eidx_r].vld) begin
            okind_r <= ems_r[eidx_r].kind; och_r <= ems_r[eidx_r].ch;
            oact_r <= ems_r[eidx_r].act; ofrom_r <= oslot_r; olast_r <= !more_rep;
          end
          eidx_r <= eidx_r + 3'd1;
        end
        ST_TICK: begin
          // hold a found repeat until the output register frees, one slot per cycle
          if (32'(tslot_r) < SLOT_COUNT) begin
            if (tem_r.vld && (t_due && t_em.vld) ) begin
              if (out_free) begin
                if (ocnt_r < 4'(MaxOut)) begin
                  okind_r <= tem_r.kind; och_r <= tem_r.ch;
                  oact_r <= tem_r.act; ofrom_r <= oslot_r; olast_r <= 1'b0;
                  ocnt_r <= ocnt_r + 4'd1;
                end
                tem_r <= t_em; oslot_r <= 4'(t_idx);
                rdl_r[t_idx] <= now_r + 40'(per_r);
                tslot_r <= tslot_r + 1'b1;
              end
            end else begin
              if (t_due) begin
                rdl_r[t_idx] <= now_r + 40'(per_r);
                if (t_em.vld) begin tem_r <= t_em; oslot_r <= 4'(t_idx); end
              end
              tslot_r <= tslot_r + 1'b1;
            end
          end
        end
        ST_TEMIT: if (out_free) begin
          if (tem_r.vld && ocnt_r < 4'(MaxOut)) begin
            okind_r <= tem_r.kind; och_r <= tem_r.ch;
            oact_r <= tem_r.act; ofrom_r <= oslot_r; olast_r <= 1'b1;
          end
          tlast_r <= tem_r.vld;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.kind        = okind_r;
  assign out_ch.char_byte   = och_r;
  assign out_ch.action_code = oact_r;
  assign out_ch.from_slot   = ofrom_r;
  assign out_ch.last        = olast_r;

  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_ch.ready |=> ovld_r && $stable(och_r)) else $error("result lost");
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> ofrom_r != 4'd0) else $error("result from slot 0");
  a_tlast: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TEMIT && out_free |=> tlast_r == $past(tem_r.vld))
    else $error("tick end flag");
endmodule

FILE: bench/typematic_checker.sv
// Checker: tracks keyboard slot state, predicts console results and compares them.
`timescale 1ns / 100ps
module typematic_checker (
  input  logic        clk,
  input  logic        rst_n,
  hkt_in_if           in_mon,
  hkt_out_if          out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          items_seen,
  output int          results_seen
);
  import hkt_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] act;
    logic [3:0] slot;
    logic       last;
  } key_out_t;

  localparam logic [4:0] ActDelLeft  = 5'd16;
  localparam logic [4:0] ActDelRight = 5'd17;

  key_out_t   expected_keys[$];
  key_out_t   step_keys[$];

  logic        raw_q;
  logic [15:0] delay_q;
  logic [15:0] period_q;

  logic        active[16];
  logic [63:0] gen_q[16];
  logic [7:0]  held[16][6];
  logic [7:0]  rep_code[16];
  logic [7:0]  rep_mods[16];
  logic [4:0]  rep_act[16];
  logic [39:0] rep_due[16];

  assign pending = expected_keys.size();

  function automatic logic ctrl_on(logic [7:0] m);
    return (m & 8'h11) != 0;
  endfunction
  function automatic logic shift_on(logic [7:0] m);
    return (m & 8'h22) != 0;
  endfunction
  function automatic logic alt_on(logic [7:0] m);
    return (m & 8'h44) != 0;
  endfunction

  function automatic logic [7:0] key_char(logic [7:0] k, logic sh);
    string digits_up;
    string punct_lo;
    string punct_up;
    digits_up = "!@#$%^&*()";
    punct_lo  = "-=[]\\\\;'`,./";
    punct_up  = "_+{}||:\"~<>?";
    if (k >= 8'h04 && k <= 8'h1D) return (sh ? 8'h41 : 8'h61) + k - 8'h04;
    if (k >= 8'h1E && k <= 8'h26) return sh ? digits_up[k - 8'h1E] : 8'h31 + k - 8'h1E;
    if (k == 8'h27) return sh ? 8'h29 : 8'h30;
    if (k == 8'h28) return 8'h0A;
    if (k == 8'h2A) return 8'h08;
    if (k == 8'h2B) return 8'h09;
    if (k == 8'h2C) return 8'h20;
    if (k >= 8'h2D && k <= 8'h38) return sh ? punct_up[k - 8'h2D] : punct_lo[k - 8'h2D];
    return 8'h00;
  endfunction

  function automatic logic [4:0] key_action(logic [7:0] k, logic [7:0] m);
    logic s, a;
    s = shift_on(m);
    a = alt_on(m);
    if (ctrl_on(m)) return 5'd0;
    if (a) begin
      case (k)
        8'h0B: return s ? 5'd2 : 5'd1;
        8'h0F: return s ? 5'd4 : 5'd3;
        8'h05: return s ? 5'd6 : 5'd5;
        8'h1A: return s ? 5'd8 : 5'd7;
        8'h04: return s ? 5'd10 : 5'd9;
        8'h08: return s ? 5'd12 : 5'd11;
        default: ;
      endcase
    end
    case (k)
      8'h50: return s ? 5'd2 : 5'd1;
      8'h4F: return s ? 5'd4 : 5'd3;
      8'h4A: return s ? 5'd10 : 5'd9;
      8'h4D: return s ? 5'd12 : 5'd11;
      8'h2A: return a ? 5'd13 : ActDelLeft;
      8'h4C: return ActDelRight;
      8'h52: return 5'd14;
      8'h51: return 5'd15;
      default: return 5'd0;
    endcase
  endfunction

  function automatic void emit(logic [1:0] kind, logic [7:0] ch, logic [3:0] act,
                               logic [3:0] s);
    key_out_t r;
    if (step_keys.size() >= MaxOut) return;
    r = '{kind: kind, ch: ch, act: act, slot: s, last: 1'b0};
    step_keys.push_back(r);
  endfunction

  function automatic void emit_action(logic [4:0] a, logic [3:0] s);
    if (a == ActDelLeft) emit(KIND_CHAR, 8'h08, 4'd0, s);
    else if (a == ActDelRight) emit(KIND_CHAR, 8'h7F, 4'd0, s);
    else if (a != 5'd0) emit(KIND_ACT, 8'h00, 4'(a - 5'd1), s);
  endfunction

  function automatic logic emit_raw(logic [7:0] k, logic sh, logic [3:0] s);
    logic [7:0] c;
    if (k == 8'h29) begin
      emit(KIND_CHAR, 8'h1B, 4'd0, s);
      return 1'b1;
    end
    c = key_char(k, sh);
    if (c == 0) return 1'b0;
    emit(KIND_CHAR, c, 4'd0, s);
    return 1'b1;
  endfunction

  function automatic void wipe_slot(int s);
    active[s] = 0;
    gen_q[s] = '0;
    for (int j = 0; j < 6; j++) held[s][j] = '0;
    rep_code[s] = '0;
    rep_mods[s] = '0;
    rep_act[s] = '0;
    rep_due[s] = '0;
  endfunction

  function automatic void arm_repeat(int s, logic [7:0] k, logic [7:0] m, logic [39:0] now);
    rep_mods[s] = m;
    rep_act[s] = key_action(k, m);
    rep_due[s] = now + 40'(delay_q);
    rep_code[s] = k;
  endfunction

  function automatic void apply_report(int s, logic [63:0] g, logic [7:0] m,
                                       logic [7:0] keys[6], logic [7:0] count,
                                       logic [39:0] now);
    int n;
    logic [7:0] fresh, k, c;
    logic [4:0] a;
    logic is_new, still_down;
    n = count > 6 ? 6 : int'(count);
    fresh = 0;
    if (!active[s] || gen_q[s] != g) begin
      wipe_slot(s);
      active[s] = 1;
      gen_q[s] = g;
    end
    for (int i = 0; i < n; i++) begin
      k = keys[i];
      is_new = 1;
      for (int j = 0; j < 6; j++) if (held[s][j] == k) is_new = 0;
      if (is_new && k < 8'd128) begin
        if (raw_q) begin
          if (emit_raw(k, shift_on(m), 4'(s))) fresh = k;
        end else begin
          a = key_action(k, m);
          if (a != 0) begin
            emit_action(a, 4'(s));
            fresh = k;
          end else begin
            c = key_char(k, shift_on(m));
            if (c != 0) begin
              emit(KIND_CHAR, c, 4'd0, 4'(s));
              fresh = k;
            end
          end
        end
      end
    end
    if (fresh != 0) arm_repeat(s, fresh, m, now);
    else if (rep_code[s] != 0) begin
      still_down = 0;
      for (int i = 0; i < n; i++) if (keys[i] == rep_code[s]) still_down = 1;
      if (still_down) rep_mods[s] = m;
      else if (n > 0) arm_repeat(s, keys[n - 1], m, now);
      else begin
        rep_code[s] = 0;
        rep_mods[s] = 0;
        rep_act[s] = 0;
        rep_due[s] = 0;
      end
    end
    for (int i = 0; i < 6; i++) held[s][i] = i < n ? keys[i] : 8'h00;
  endfunction

  function automatic void apply_tick(logic [39:0] now);
    logic [7:0] c;
    for (int s = 1; s < 16; s++) begin
      if (active[s] && rep_code[s] != 0 && now >= rep_due[s]) begin
        if (rep_act[s] != 0) begin
          if (key_action(rep_code[s], rep_mods[s]) == rep_act[s])
            emit_action(rep_act[s], 4'(s));
        end else if (raw_q) begin
          void'(emit_raw(rep_code[s], shift_on(rep_mods[s]), 4'(s)));
        end else begin
          c = key_char(rep_code[s], shift_on(rep_mods[s]));
          if (c != 0) emit(KIND_CHAR, c, 4'd0, 4'(s));
        end
        rep_due[s] = now + 40'(period_q);
      end
    end
  endfunction

  function automatic void predict_item();
    logic [7:0] keys[6];
    int s;
    step_keys.delete();
    keys[0] = in_mon.key_a; keys[1] = in_mon.key_b; keys[2] = in_mon.key_c;
    keys[3] = in_mon.key_d; keys[4] = in_mon.key_e; keys[5] = in_mon.key_f;
    s = int'(in_mon.slot);
    if (in_mon.cmd == CMD_TICK) apply_tick(in_mon.now_ms);
    else if ((in_mon.cmd == CMD_REPORT || in_mon.cmd == CMD_REMOVE) && s != 0 &&
             in_mon.generation != 0) begin
      if (in_mon.cmd == CMD_REPORT)
        apply_report(s, in_mon.generation, in_mon.modifiers, keys, in_mon.key_count,
                     in_mon.now_ms);
      else if (active[s] && gen_q[s] == in_mon.generation) wipe_slot(s);
    end
    if (step_keys.size() > 0) step_keys[step_keys.size() - 1].last = 1'b1;
    foreach (step_keys[i]) expected_keys.push_back(step_keys[i]);
  endfunction

  always @(posedge clk) begin
    key_out_t got, want;
    if (!rst_n) begin
      raw_q <= 0;
      delay_q <= 16'd400;
      period_q <= 16'd40;
      for (int s = 0; s < 16; s++) wipe_slot(s);
      expected_keys.delete();
      fail_count <= 0;
      items_seen <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_RAW:    raw_q <= cfg_pwdata[0];
          REG_DELAY:  delay_q <= cfg_pwdata[15:0];
          REG_PERIOD: period_q <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_item();
        items_seen <= items_seen + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        got = '{kind: out_mon.kind, ch: out_mon.char_byte, act: out_mon.action_code,
                slot: out_mon.from_slot, last: out_mon.last};
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected result kind=%0d byte=%h act=%0d slot=%0d last=%0b",
                   $time, got.kind, got.ch, got.act, got.slot, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_keys.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d byte=%h act=%0d slot=%0d last=%0b",
                     $time, want.kind, want.ch, want.act, want.slot, want.last);
            $display("%0t:          actual   kind=%0d byte=%h act=%0d slot=%0d last=%0b",
                     $time, got.kind, got.ch, got.act, got.slot, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/hid_keyboard_report_typematic_core_test.sv
// Testbench top: drives reports, ticks, removals and register writes into the core.
`timescale 1ns / 100ps
module hid_keyboard_report_typematic_core_test;
  import hkt_pkg::*;

  localparam int IdleLimit = 4000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, items_seen, results_seen;
  int          idle_cycles = 0;
  int          stall_mode = 0, stall_cnt = 0;
  logic [39:0] clock_ms = 40'd1000;
  logic [7:0]  last_keys[16][6];
  logic [63:0] slot_gen[16];

  logic [7:0] hot_keys[] = '{8'h04, 8'h05, 8'h08, 8'h0B, 8'h0F, 8'h1A, 8'h1E, 8'h27,
                             8'h28, 8'h29, 8'h2A, 8'h2C, 8'h2D, 8'h31, 8'h38, 8'h39,
                             8'h4A, 8'h4C, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h00};

  hkt_in_if  in_ch();
  hkt_out_if out_ch();

  always #2 clk = ~clk;

  hid_keyboard_report_typematic_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typematic_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending), .items_seen(items_seen),
    .results_seen(results_seen)
  );

  initial begin
    in_ch.valid = 0; in_ch.cmd = CMD_TICK; in_ch.slot = 0; in_ch.generation = 0;
    in_ch.modifiers = 0; in_ch.key_a = 0; in_ch.key_b = 0; in_ch.key_c = 0;
    in_ch.key_d = 0; in_ch.key_e = 0; in_ch.key_f = 0; in_ch.key_count = 0;
    in_ch.now_ms = 0;
    out_ch.ready = 0;
  end

  // Receiver: switch between free flow, random stalls and long stalls.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 120 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: nothing moving on any port for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [3:0] slot, logic [63:0] g, logic [7:0] m,
                      logic [7:0] k[6], logic [7:0] count, logic [39:0] now);
    logic r;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd; in_ch.slot <= slot; in_ch.generation <= g; in_ch.modifiers <= m;
    in_ch.key_a <= k[0]; in_ch.key_b <= k[1]; in_ch.key_c <= k[2];
    in_ch.key_d <= k[3]; in_ch.key_e <= k[4]; in_ch.key_f <= k[5];
    in_ch.key_count <= count; in_ch.now_ms <= now;
    do begin
      @(negedge clk);
      r = in_ch.ready;
      @(posedge clk);
    end while (!r);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a tick may still be walking slots without producing anything
    repeat (64) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_key(int s);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return hot_keys[$urandom_range(0, hot_keys.size() - 1)];
    if (r < 88) return last_keys[s][$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  task automatic random_item();
    logic [7:0] k[6];
    logic [63:0] g;
    logic [7:0] m, count;
    logic [3:0] s;
    logic [1:0] cmd;
    int r;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    g = slot_gen[s];
    if ($urandom_range(0, 29) == 0) g = 0;
    else if ($urandom_range(0, 29) == 0) g = {$urandom, $urandom};
    else if ($urandom_range(0, 14) == 0) begin
      slot_gen[s] = slot_gen[s] + 1;
      g = slot_gen[s];
    end
    m = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
    count = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6));
    for (int i = 0; i < 6; i++) k[i] = pick_key(s);
    clock_ms = clock_ms + 40'($urandom_range(0, 80));
    if ($urandom_range(0, 99) == 0) clock_ms = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 500));
    if (r < 60) cmd = CMD_REPORT;
    else if (r < 85) cmd = CMD_TICK;
    else if (r < 95) cmd = CMD_REMOVE;
    else cmd = 2'd3;
    send(cmd, s, g, m, k, count, ($urandom_range(0, 49) == 0) ? {8'($urandom), $urandom}
                                                              : clock_ms);
    if (cmd == CMD_REPORT) for (int i = 0; i < 6; i++) last_keys[s][i] = k[i];
    gap();
  endtask

  task automatic directed();
    logic [7:0] z[6], nav[6], alt[6], mixed[6], wide[6];
    z = '{default: 8'h00};
    nav = '{8'h50, 8'h4F, 8'h4A, 8'h4D, 8'h2A, 8'h4C};
    alt = '{8'h0B, 8'h0F, 8'h05, 8'h1A, 8'h04, 8'h08};
    mixed = '{8'h29, 8'h52, 8'h51, 8'h38, 8'h1E, 8'h80};
    wide = '{8'hFF, 8'h7F, 8'h39, 8'h28, 8'h2B, 8'h2C};
    send(CMD_REPORT, 4'd0, 64'd1, 8'h00, nav, 8'd6, 40'd0);          // slot 0 ignored
    send(CMD_REPORT, 4'd1, 64'd0, 8'h00, nav, 8'd6, 40'd0);          // generation 0 ignored
    send(CMD_REPORT, 4'd1, 64'd1, 8'h00, nav, 8'd255, 40'd10);
    send(CMD_REPORT, 4'd1, 64'd1, 8'h22, nav, 8'd6, 40'd20);         // all held, no output
    send(CMD_REPORT, 4'd2, 64'd1, 8'h44, alt, 8'd6, 40'd30);
    send(CMD_REPORT, 4'd3, 64'd1, 8'h66, alt, 8'd6, 40'd30);
    send(CMD_REPORT, 4'd4, 64'd1, 8'h11, alt, 8'd6, 40'd30);         // ctrl kills actions
    send(CMD_REPORT, 4'd5, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, mixed, 8'd6, 40'd40);
    send(CMD_REPORT, 4'd6, 64'd1, 8'h00, wide, 8'd6, 40'd40);
    send(CMD_REPORT, 4'd7, 64'd1, 8'h00, mixed, 8'd7, 40'd40);
    send(CMD_REPORT, 4'd6, 64'd1, 8'h00, '{8'h39, 8'h28, 8'h27, 0, 0, 0}, 8'd2, 40'd50);
    for (int s = 8; s < 16; s++)
      send(CMD_REPORT, 4'(s), 64'(s), 8'h02, '{8'h04 + 8'(s), 0, 0, 0, 0, 0}, 8'd1, 40'd60);
    send(CMD_TICK, 4'd0, 64'd0, 8'h00, z, 8'd0, 40'd5000);           // many slots due
    send(CMD_REMOVE, 4'd1, 64'd9, 8'h00, z, 8'd0, 40'd5000);         // wrong generation
    send(CMD_REMOVE, 4'd1, 64'd1, 8'h00, z, 8'd0, 40'd5000);
    send(2'd3, 4'd2, 64'd1, 8'h00, z, 8'd0, 40'd5000);
    send(CMD_REPORT, 4'd2, 64'd1, 8'h00, z, 8'd0, 40'd5001);          // release all
    send(CMD_TICK, 4'd0, 64'd0, 8'h00, z, 8'd0, 40'hFF_FFFF_FFFF);
  endtask

  initial begin
    for (int s = 0; s < 16; s++) begin
      slot_gen[s] = 64'd1;
      for (int i = 0; i < 6; i++) last_keys[s][i] = 8'h00;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    settle();
    reg_write(REG_RAW, 32'd0);
    reg_write(REG_DELAY, 32'd400);
    reg_write(REG_PERIOD, 32'd40);
    repeat (140) random_item();
    settle();
    reg_write(REG_RAW, 32'hFFFF_FFFF);
    reg_write(REG_DELAY, 32'd0);
    reg_write(REG_PERIOD, 32'd1);
    directed();
    repeat (130) random_item();
    settle();
    reg_write(REG_RAW, 32'h0000_0000);
    reg_write(REG_DELAY, 32'hFFFF_FFFF);
    reg_write(REG_PERIOD, 32'hFFFF_FFFF);
    repeat (100) random_item();
    settle();
    $display("Covered %0d transactions in three register settings (raw/cooked, delay and",
             items_seen);
    $display("period at both extremes); %0d results compared.", results_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: hid_keyboard_report_typematic_core.f
design/hkt_pkg.sv
design/hkt_if.sv
design/hkt_lane.sv
design/hkt_merge.sv
design/hid_keyboard_report_typematic_core.sv
bench/typematic_checker.sv
bench/hid_keyboard_report_typematic_core_test.sv
